[src/lbws_pkg.sv]
// Package: shared constants, types and codes for the bracket and word scanner.
`timescale 1ns / 1ps

package lbws_pkg;

  // Bracket stack geometry
  localparam int MaxDepth = 64;
  localparam int AddrW    = $clog2(MaxDepth);
  localparam int DepthW   = $clog2(MaxDepth + 1);

  // Result queue geometry
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Hash constants
  localparam logic [63:0] HashSeed = 64'd85917378991987918;
  localparam logic [63:0] HashMul  = 64'd13745795198;
  localparam logic [63:0] HashSub  = 64'd998573153;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_WORD       = 3'd0,
    KIND_OK         = 3'd1,
    KIND_BAD_CLOSE  = 3'd2,
    KIND_UNCLOSED   = 3'd3,
    KIND_OVERFLOW   = 3'd4
  } kind_e;

  // Bracket codes as kept on the stack
  typedef enum logic [1:0] {
    BRK_PAREN  = 2'd0,
    BRK_SQUARE = 2'd1,
    BRK_CURLY  = 2'd2
  } brk_e;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic [31:0] word_start;
    logic [31:0] word_length;
    logic [63:0] word_hash;
    logic [31:0] position;
    logic        final_res;
  } result_t;

  // Results produced by one input transfer
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

[src/lbws_ram.sv]
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module lbws_ram #(
  parameter int Width = 2,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/lbws_core.sv]
// Scanner core: bracket stack, comment skip, word tracking and streaming hash.
`timescale 1ns / 1ps

module lbws_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     ch_i,
  input  logic           last_i,
  output lbws_pkg::push_t push_o
);
  import lbws_pkg::*;

  // Rotate right of a 64-bit word
  function automatic logic [63:0] rotr64(input logic [63:0] x, input logic [5:0] r);
    logic [127:0] dbl;
    dbl = {x, x} >> r;
    return dbl[63:0];
  endfunction

  // State registers
  logic [DepthW-1:0] depth_q, depth_d;
  brk_e              top_q, top_d;
  logic              in_comment_q, in_comment_d;
  logic              word_active_q, word_active_d;
  logic [31:0]       word_begin_q, word_begin_d;
  logic [31:0]       word_count_q, word_count_d;
  logic [63:0]       hash_q, hash_d;
  logic [5:0]        rotsum_q, rotsum_d;
  logic [31:0]       pos_q, pos_d;
  logic              halted_q, halted_d;

  // Stack memory interface
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [AddrW-1:0]  ram_raddr;
  logic [1:0]        ram_rdata;
  logic [DepthW-1:0] below_top;

  // Byte classification
  logic        is_open, is_close, is_word;
  brk_e        code;
  logic [63:0] kmul;
  logic [63:0] word_seed;
  logic [63:0] word_hash;
  logic [63:0] base_hash;
  logic [5:0]  base_rot;
  logic [31:0] base_count;

  // Per-byte decisions
  logic              err;
  kind_e             err_kind;
  logic              word_mode;
  logic              has_word;
  logic              has_end;
  logic              clear_all;
  logic [DepthW-1:0] depth_end;
  result_t           word_res, end_res, err_res;

  always_comb begin
    is_open  = (ch_i == "(") || (ch_i == "[") || (ch_i == "{");
    is_close = (ch_i == ")") || (ch_i == "]") || (ch_i == "}");
    is_word  = ((ch_i >= "a") && (ch_i <= "z")) || ((ch_i >= "A") && (ch_i <= "Z")) ||
               ((ch_i >= "0") && (ch_i <= "9"));
    if ((ch_i == "(") || (ch_i == ")")) begin
      code = BRK_PAREN;
    end else if ((ch_i == "[") || (ch_i == "]")) begin
      code = BRK_SQUARE;
    end else begin
      code = BRK_CURLY;
    end
  end

  // Per-character hash term and finished word hash
  assign kmul      = 64'(ch_i) * HashMul - HashSub;
  assign word_seed = HashSeed - 64'(word_count_q);
  assign word_hash = hash_q ^ rotr64(word_seed, rotsum_q);

  // A new word restarts the hash from zero
  assign base_hash  = word_active_q ? hash_q : 64'd0;
  assign base_rot   = word_active_q ? rotsum_q : 6'd0;
  assign base_count = word_active_q ? word_count_q : 32'd0;

  // Next state and results
  always_comb begin
    depth_d       = depth_q;
    top_d         = top_q;
    in_comment_d  = in_comment_q;
    word_active_d = word_active_q;
    word_begin_d  = word_begin_q;
    word_count_d  = word_count_q;
    hash_d        = hash_q;
    rotsum_d      = rotsum_q;
    pos_d         = pos_q;
    halted_d      = halted_q;
    ram_we        = 1'b0;
    ram_waddr     = depth_q[AddrW-1:0];
    err           = 1'b0;
    err_kind      = KIND_BAD_CLOSE;
    word_mode     = 1'b0;
    has_word      = 1'b0;
    has_end       = 1'b0;
    clear_all     = 1'b0;

    if (accept_i) begin
      if (halted_q) begin
        // Text already failed: wait for its last byte
        clear_all = last_i;
      end else begin
        if (in_comment_q) begin
          if (ch_i == 8'h0A) begin
            in_comment_d = 1'b0;
          end
        end else if (is_open) begin
          if (depth_q == DepthW'(MaxDepth)) begin
            err      = 1'b1;
            err_kind = KIND_OVERFLOW;
          end else begin
            ram_we  = 1'b1;
            top_d   = code;
            depth_d = depth_q + DepthW'(1);
          end
        end else if (is_close) begin
          if ((depth_q == '0) || (top_q != code)) begin
            err      = 1'b1;
            err_kind = KIND_BAD_CLOSE;
          end else begin
            depth_d = depth_q - DepthW'(1);
            top_d   = brk_e'(ram_rdata);
          end
        end else if (ch_i == ";") begin
          in_comment_d = 1'b1;
        end else if (is_word) begin
          word_mode     = 1'b1;
          word_active_d = 1'b1;
          if (!word_active_q) begin
            word_begin_d = pos_q;
          end
          hash_d       = rotr64(base_hash ^ kmul, ch_i[5:0]);
          rotsum_d     = base_rot + ch_i[5:0];
          word_count_d = base_count + 32'd1;
        end

        if (err) begin
          clear_all = 1'b1;
        end else begin
          // Any non-word byte closes an open word
          if (!in_comment_q && word_active_q && !word_mode) begin
            has_word      = 1'b1;
            word_active_d = 1'b0;
          end
          if (last_i) begin
            has_end   = 1'b1;
            clear_all = 1'b1;
          end else begin
            pos_d = pos_q + 32'd1;
          end
        end
      end
    end

    // Stack depth after this byte, before any end-of-text clear
    depth_end = depth_d;

    if (clear_all) begin
      depth_d       = '0;
      in_comment_d  = 1'b0;
      word_active_d = 1'b0;
      word_begin_d  = '0;
      word_count_d  = '0;
      hash_d        = '0;
      rotsum_d      = '0;
      pos_d         = '0;
      halted_d      = err && !last_i;
    end
  end

  // Result records
  always_comb begin
    word_res             = '0;
    word_res.kind        = KIND_WORD;
    word_res.word_start  = word_begin_q;
    word_res.word_length = word_count_q;
    word_res.word_hash   = (word_hash == 64'd0) ? 64'(word_count_q) : word_hash;
    word_res.final_res   = !has_end;

    end_res           = '0;
    end_res.kind      = (depth_end != '0) ? KIND_UNCLOSED : KIND_OK;
    end_res.position  = pos_q + 32'd1;
    end_res.final_res = 1'b1;

    err_res           = '0;
    err_res.kind      = err_kind;
    err_res.position  = pos_q;
    err_res.final_res = 1'b1;

    push_o = '0;
    if (err) begin
      push_o.count = 2'd1;
      push_o.r0    = err_res;
    end else begin
      push_o.count = {1'b0, has_word} + {1'b0, has_end};
      push_o.r0    = has_word ? word_res : end_res;
      push_o.r1    = end_res;
    end
  end

  // Read the entry under the new top so a pop finds it next cycle
  assign below_top = depth_d - DepthW'(2);
  assign ram_raddr = below_top[AddrW-1:0];

  lbws_ram #(
    .Width(2),
    .Depth(MaxDepth)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(code),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q       <= '0;
      in_comment_q  <= 1'b0;
      word_active_q <= 1'b0;
      word_begin_q  <= '0;
      word_count_q  <= '0;
      hash_q        <= '0;
      rotsum_q      <= '0;
      pos_q         <= '0;
      halted_q      <= 1'b0;
    end else begin
      depth_q       <= depth_d;
      in_comment_q  <= in_comment_d;
      word_active_q <= word_active_d;
      word_begin_q  <= word_begin_d;
      word_count_q  <= word_count_d;
      hash_q        <= hash_d;
      rotsum_q      <= rotsum_d;
      pos_q         <= pos_d;
      halted_q      <= halted_d;
    end
  end

  // Cached top of stack
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

endmodule

[src/lbws_res_fifo.sv]
// Result queue: takes up to two results per cycle, delivers one per transfer.
`timescale 1ns / 1ps

module lbws_res_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lbws_pkg::push_t   push_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lbws_pkg::result_t head_o
);
  import lbws_pkg::*;

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;
  logic [FifoPtrW-1:0] wr_ptr_nxt;
  logic                pop;

  // Room for two results is needed before the next input transfer
  assign full_o      = count_q > FifoCntW'(FifoDepth - 2);
  assign out_valid_o = count_q != '0;
  assign head_o      = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_ptr_nxt  = wr_ptr_q + FifoPtrW'(1);

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + FifoPtrW'(1) : rd_ptr_q;
    count_d  = count_q + FifoCntW'(push_i.count) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.r1;
    end
  end

endmodule

[src/lisp_bracket_word_scanner.sv]
// Top level of the bracket and word scanner for Lisp-like source text.
`timescale 1ns / 1ps

// Takes one source byte per cycle while in_stall_o is low: every byte is
// classified, checked against the bracket stack and folded into the running
// word hash in the cycle it is transferred. A byte yields up to two results
// (a finished word and the end-of-text result), which go into a four-entry
// result queue that drains one result per cycle while out_stall_i is low;
// the input stalls while fewer than two queue entries are free, so
// sustained input rate is one byte per cycle as long as results average at
// most one per byte and the output is not stalled. The bracket stack lives
// in a 64 x 2 RAM with its top entry cached in a register and the entry
// beneath it pre-read, so neither push nor pop waits on a RAM read.
module lisp_bracket_word_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] word_start_o,
  output logic [31:0] word_length_o,
  output logic [63:0] word_hash_o,
  output logic [31:0] position_o,
  output logic        final_res_o
);
  import lbws_pkg::*;

  logic    accept;
  push_t   push;
  result_t head;

  // Input transfer
  assign accept = in_valid_i && !in_stall_o;

  lbws_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .ch_i    (ch_i),
    .last_i  (last_i),
    .push_o  (push)
  );

  lbws_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  // Result fields
  assign kind_o        = head.kind;
  assign word_start_o  = head.word_start;
  assign word_length_o = head.word_length;
  assign word_hash_o   = head.word_hash;
  assign position_o    = head.position;
  assign final_res_o   = head.final_res;

endmodule

[test/tb_lisp_bracket_word_scanner.sv]
// Testbench for the bracket and word scanner: random Lisp-like text, scoreboard check.
`timescale 1ns / 1ps

module tb_lisp_bracket_word_scanner;
  import lbws_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  text_ch = '0;
  logic        text_last = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  kind_o;
  logic [31:0] word_start_o;
  logic [31:0] word_length_o;
  logic [63:0] word_hash_o;
  logic [31:0] position_o;
  logic        final_res_o;

  // Bytes still to send, and results the scanner owes us
  text_byte_t text_bytes[$];
  result_t    due_results[$];
  int         bytes_total = 0;
  int         bytes_sent = 0;
  int         mismatch_count = 0;

  // Our own copy of the scanner state
  brk_e        bracket_kinds[MaxDepth];
  int          open_depth;
  bit          in_cmt;
  bit          word_open;
  bit          scan_halted;
  logic [31:0] word_beg;
  logic [31:0] word_len;
  logic [63:0] hash_acc;
  logic [5:0]  rot_sum;
  logic [31:0] scan_pos;

  // Handshake pacing
  int         gap_left = 0;
  int         stall_left = 0;
  bit         in_quiet = 1'b0;
  bit         out_quiet = 1'b0;
  text_byte_t next_byte;
  result_t    seen;
  result_t    want;

  lisp_bracket_word_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .ch_i          (text_ch),
    .last_i        (text_last),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .kind_o        (kind_o),
    .word_start_o  (word_start_o),
    .word_length_o (word_length_o),
    .word_hash_o   (word_hash_o),
    .position_o    (position_o),
    .final_res_o   (final_res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] rotate_right(input logic [63:0] x, input logic [5:0] r);
    if (r == 6'd0) return x;
    return (x >> r) | (x << (7'd64 - r));
  endfunction

  function automatic logic [7:0] open_char(input brk_e b);
    case (b)
      BRK_PAREN:  return "(";
      BRK_SQUARE: return "[";
      default:    return "{";
    endcase
  endfunction

  function automatic logic [7:0] close_char(input brk_e b);
    case (b)
      BRK_PAREN:  return ")";
      BRK_SQUARE: return "]";
      default:    return "}";
    endcase
  endfunction

  function automatic logic [7:0] alnum_char();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  function automatic logic [7:0] sep_char();
    case ($urandom_range(0, 5))
      0:       return " ";
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0D;
      4:       return "-";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic brk_e any_bracket();
    return brk_e'($urandom_range(0, 2));
  endfunction

  task automatic clear_scan();
    open_depth  = 0;
    in_cmt      = 1'b0;
    word_open   = 1'b0;
    scan_halted = 1'b0;
    word_beg    = '0;
    word_len    = '0;
    hash_acc    = '0;
    rot_sum     = '0;
    scan_pos    = '0;
  endtask

  // Advance the scanner state by one byte and queue the results it owes
  task automatic scan_byte(input logic [7:0] c, input logic is_last);
    result_t     outs[$];
    result_t     r;
    logic [31:0] pos;
    logic [63:0] h;
    brk_e        b;
    bit          word_char;
    bit          has_err;
    kind_e       err;
    pos = scan_pos;
    has_err = 1'b0;
    err = KIND_OK;
    word_char = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
    // After an error only the last byte matters
    if (scan_halted) begin
      if (is_last) clear_scan();
      return;
    end
    if (in_cmt) begin
      if (c == 8'h0A) in_cmt = 1'b0;
    end else begin
      case (c)
        "(", "[", "{": begin
          b = (c == "(") ? BRK_PAREN : ((c == "[") ? BRK_SQUARE : BRK_CURLY);
          if (open_depth >= MaxDepth) begin
            has_err = 1'b1;
            err = KIND_OVERFLOW;
          end else begin
            bracket_kinds[open_depth] = b;
            open_depth++;
          end
        end
        ")", "]", "}": begin
          b = (c == ")") ? BRK_PAREN : ((c == "]") ? BRK_SQUARE : BRK_CURLY);
          if (open_depth == 0 || bracket_kinds[open_depth - 1] != b) begin
            has_err = 1'b1;
            err = KIND_BAD_CLOSE;
          end else begin
            open_depth--;
          end
        end
        ";": in_cmt = 1'b1;
        default: begin
          if (word_char) begin
            if (!word_open) begin
              word_open = 1'b1;
              word_beg  = pos;
              word_len  = '0;
              hash_acc  = '0;
              rot_sum   = '0;
            end
            hash_acc = rotate_right(hash_acc ^ (64'(c) * HashMul - HashSub), c[5:0]);
            rot_sum  = rot_sum + c[5:0];
            word_len = word_len + 1;
          end
        end
      endcase

      // An error drops any pending word and ends the text
      if (has_err) begin
        r = '0;
        r.kind = err;
        r.position = pos;
        r.final_res = 1'b1;
        due_results.push_back(r);
        clear_scan();
        scan_halted = !is_last;
        return;
      end

      if (word_open && !word_char) begin
        h = hash_acc ^ rotate_right(HashSeed - 64'(word_len), rot_sum);
        if (h == 64'd0) h = 64'(word_len);
        r = '0;
        r.kind = KIND_WORD;
        r.word_start = word_beg;
        r.word_length = word_len;
        r.word_hash = h;
        outs.push_back(r);
        word_open = 1'b0;
      end
    end

    if (is_last) begin
      r = '0;
      r.kind = (open_depth != 0) ? KIND_UNCLOSED : KIND_OK;
      r.position = pos + 32'd1;
      outs.push_back(r);
      clear_scan();
    end else begin
      scan_pos = pos + 32'd1;
    end

    if (outs.size() != 0) outs[outs.size() - 1].final_res = 1'b1;
    foreach (outs[i]) due_results.push_back(outs[i]);
  endtask

  task automatic add_byte(input logic [7:0] c, input logic is_last);
    text_byte_t t;
    t.ch = c;
    t.last = is_last;
    text_bytes.push_back(t);
  endtask

  task automatic add_string(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
  endtask

  // One random text: mostly well-formed bracket and word structure
  task automatic add_random_text();
    brk_e       open_kinds[$];
    logic [7:0] text[$];
    brk_e       b;
    int         style;
    int         wlen;
    style = $urandom_range(0, 19);
    if (style == 0) begin
      // one bracket past the stack limit
      repeat (MaxDepth + 1) text.push_back(open_char(any_bracket()));
      repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      // exactly full stack
      if (style == 1) begin
        repeat (MaxDepth) begin
          b = any_bracket();
          open_kinds.push_back(b);
          text.push_back(open_char(b));
        end
      end
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3, 4, 5: begin
            wlen = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 80) : $urandom_range(1, 10);
            repeat (wlen) text.push_back(alnum_char());
          end
          6, 7: text.push_back(sep_char());
          8, 9: begin
            if (open_kinds.size() < MaxDepth) begin
              b = any_bracket();
              open_kinds.push_back(b);
              text.push_back(open_char(b));
            end
          end
          10, 11: begin
            if (open_kinds.size() != 0) text.push_back(close_char(open_kinds.pop_back()));
          end
          12: begin
            text.push_back(";");
            repeat ($urandom_range(0, 6)) begin
              if ($urandom_range(0, 1) == 0) text.push_back(alnum_char());
              else text.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 3) != 0) text.push_back(8'h0A);
          end
          13: text.push_back(close_char(any_bracket()));
          14: text.push_back(8'($urandom_range(0, 255)));
          default: begin
            while (open_kinds.size() != 0) text.push_back(close_char(open_kinds.pop_back()));
          end
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        while (open_kinds.size() != 0) text.push_back(close_char(open_kinds.pop_back()));
      end
    end
    if (text.size() == 0) text.push_back(alnum_char());
    foreach (text[i]) add_byte(text[i], i == text.size() - 1);
  endtask

  // Fill the byte queue: directed texts first, then random texts
  initial begin
    clear_scan();
    // word ended by bracket and by comment, comment closed by newline
    add_string("Az09(x;c\n)");
    // bad close on empty stack drops the pending word
    add_string("w}");
    // mismatched close, then ignored bytes up to the last one
    add_string("([)abc");
    // word open at end of text is not reported, stack left open
    add_string("{k");
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    while (text_bytes.size() < 1750) add_random_text();
    bytes_total = text_bytes.size();
  end

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      text_ch   <= '0;
      text_last <= 1'b0;
      gap_left = 0;
    end else begin
      if ($urandom_range(0, 249) == 0) in_quiet = !in_quiet;
      if (!(in_valid && in_stall_o)) begin
        if (in_valid) begin
          scan_byte(text_ch, text_last);
          bytes_sent++;
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (text_bytes.size() != 0) begin
          if (!in_quiet && text_bytes.size() >= 200 && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 4);
            in_valid <= 1'b0;
          end else begin
            next_byte = text_bytes.pop_front();
            text_ch   <= next_byte.ch;
            text_last <= next_byte.last;
            in_valid  <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and scoreboard
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        seen = '{kind_e'(kind_o), word_start_o, word_length_o, word_hash_o, position_o,
                 final_res_o};
        if (due_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: kind %0d start %0d len %0d hash %h pos %0d final %0d",
                     kind_o, word_start_o, word_length_o, word_hash_o, position_o,
                     final_res_o);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (seen !== want) begin
            if (mismatch_count < 10) begin
              $display("expected: kind %0d start %0d len %0d hash %h pos %0d final %0d",
                       want.kind, want.word_start, want.word_length, want.word_hash,
                       want.position, want.final_res);
              $display("actual:   kind %0d start %0d len %0d hash %h pos %0d final %0d",
                       kind_o, word_start_o, word_length_o, word_hash_o, position_o,
                       final_res_o);
            end
            mismatch_count++;
          end
        end
      end
      if ($urandom_range(0, 249) == 0) out_quiet = !out_quiet;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!out_quiet && text_bytes.size() >= 200 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Reset, drain and verdict
  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (bytes_total == 0 || bytes_sent != bytes_total) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    // the result queue is four deep; give stray results time to show
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("lisp_bracket_word_scanner: match");
    end else begin
      $display("lisp_bracket_word_scanner: mismatch");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5000000;
    $display("lisp_bracket_word_scanner: mismatch");
    $finish;
  end

endmodule

[lisp_bracket_word_scanner.f]
src/lbws_pkg.sv
src/lbws_ram.sv
src/lbws_core.sv
src/lbws_res_fifo.sv
src/lisp_bracket_word_scanner.sv
test/tb_lisp_bracket_word_scanner.sv
